[design/bmi_pkg.sv]
// Package for the binary modular inverse block.
// Holds the operand width, derived widths, sequencer states and the result type.
// No dependencies.
package bmi_pkg;

	// Operand width of value and modulus
	localparam int WIDTH = 32;
	// A positive modulus and every residue fit in one bit less
	localparam int RES_W = WIDTH - 1;
	// Bit counter for one pass of the shift-subtract unit
	localparam int CNT_W = $clog2(WIDTH);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);
	// Stream widths: two operands in, inverse padded to whole bytes out
	localparam int IN_TDATA_W  = 2 * WIDTH;
	localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_FIX,
		ST_CHECK,
		ST_DIV,
		ST_UPDATE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             no_inverse;
		logic [RES_W-1:0] inverse;
	} res_t;

endpackage

[design/bmi_step.sv]
// One step of the shared shift-subtract unit: restoring division by one bit
// and the matching Horner step of (quotient * addend) mod modulus.
// Depends on bmi_pkg.
module bmi_step import bmi_pkg::*; (
	input  logic [RES_W-1:0] rem,
	input  logic             din,
	input  logic [RES_W-1:0] divisor,
	input  logic [RES_W-1:0] acc,
	input  logic [RES_W-1:0] addend,
	input  logic [RES_W-1:0] modulus,
	output logic [RES_W-1:0] rem_nx,
	output logic [RES_W-1:0] acc_nx
);

	logic [WIDTH-1:0] shifted;
	logic [WIDTH-1:0] diff;
	logic             take;
	logic [WIDTH-1:0] dbl;
	logic [WIDTH-1:0] dbl_red;
	logic [WIDTH-1:0] sum;
	logic [WIDTH-1:0] sum_red;

	// Bring in the next dividend bit and subtract the divisor when it fits
	always_comb begin
		shifted = {rem, din};
		take    = shifted >= {1'b0, divisor};
		diff    = shifted - {1'b0, divisor};
		rem_nx  = take ? diff[RES_W-1:0] : shifted[RES_W-1:0];
	end

	// Double the product so far mod modulus, then add the addend on a quotient one
	always_comb begin
		dbl     = {acc, 1'b0};
		dbl_red = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
		sum     = dbl_red + (take ? {1'b0, addend} : '0);
		sum_red = (sum >= {1'b0, modulus}) ? sum - {1'b0, modulus} : sum;
		acc_nx  = sum_red[RES_W-1:0];
	end

endmodule

[design/bmi_core.sv]
// Sequencer and registers of the modular inverse: reduction of the value,
// Euclid steps on the shared shift-subtract unit, and the final check.
// Depends on bmi_pkg and bmi_step.
module bmi_core import bmi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_value,
	input  logic [WIDTH-1:0] in_modulus,
	output logic             res_valid,
	input  logic             res_ready,
	output res_t             res
);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] dvd_q;
	logic [RES_W-1:0] rem_q, acc_q;
	logic [RES_W-1:0] m_q, r0_q, r1_q, t0_q, t1_q;
	logic             neg_q;
	res_t             res_q;

	logic             in_fire;
	logic             bad_mod;
	logic [RES_W-1:0] divisor;
	logic [RES_W-1:0] rem_nx, acc_nx;
	logic [RES_W-1:0] reduced;
	logic [RES_W-1:0] t_next;

	assign in_fire = in_valid && in_ready;
	assign bad_mod = in_modulus[WIDTH-1] || (in_modulus == '0);
	assign divisor = (state_q == ST_REDUCE) ? m_q : r1_q;

	bmi_step u_step (
		.rem     (rem_q),
		.din     (dvd_q[WIDTH-1]),
		.divisor (divisor),
		.acc     (acc_q),
		.addend  (t1_q),
		.modulus (m_q),
		.rem_nx  (rem_nx),
		.acc_nx  (acc_nx)
	);

	// Residue of the value, and t0 - q*t1 mod modulus
	assign reduced = (neg_q && rem_q != '0) ? m_q - rem_q : rem_q;
	assign t_next  = (t0_q >= acc_q) ? t0_q - acc_q : t0_q + (m_q - acc_q);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = bad_mod ? ST_DONE : ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (cnt_q == '0) begin
					state_d = ST_FIX;
				end
			end
			ST_FIX: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = (r1_q == '0) ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = ST_CHECK;
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Bit counter of the shared unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_fire || state_q == ST_CHECK) begin
			cnt_q <= CNT_LAST;
		end else if (state_q == ST_REDUCE || state_q == ST_DIV) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					m_q   <= in_modulus[RES_W-1:0];
					neg_q <= in_value[WIDTH-1];
					dvd_q <= in_value[WIDTH-1] ? '0 - in_value : in_value;
					rem_q <= '0;
					res_q <= '{no_inverse: 1'b1, inverse: '0};
				end
			end
			ST_REDUCE, ST_DIV: begin
				rem_q <= rem_nx;
				acc_q <= acc_nx;
				dvd_q <= {dvd_q[WIDTH-2:0], 1'b0};
			end
			ST_FIX: begin
				r0_q <= m_q;
				r1_q <= reduced;
				t0_q <= '0;
				t1_q <= (m_q == RES_W'(1)) ? '0 : RES_W'(1);
			end
			ST_CHECK: begin
				dvd_q <= {1'b0, r0_q};
				rem_q <= '0;
				acc_q <= '0;
				if (r1_q == '0) begin
					if (r0_q == RES_W'(1)) begin
						res_q <= '{no_inverse: 1'b0, inverse: t0_q};
					end else begin
						res_q <= '{no_inverse: 1'b1, inverse: '0};
					end
				end
			end
			ST_UPDATE: begin
				r0_q <= r1_q;
				r1_q <= rem_q;
				t0_q <= t1_q;
				t1_q <= t_next;
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;

	// Invalid modulus goes straight to a no-inverse result
	a_bad_mod: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && bad_mod |=> state_q == ST_DONE && res_q.no_inverse)
		else $error("bad modulus did not give a no-inverse result");

	// Partial remainder stays below the divisor during a pass
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REDUCE || state_q == ST_DIV) |-> rem_q < divisor)
		else $error("partial remainder reached the divisor");

	// Euclid invariants at each check
	a_euclid_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHECK |-> r1_q < r0_q && t0_q < m_q && t1_q < m_q)
		else $error("Euclid registers out of range");

	// A found inverse is a residue; a missing one reads as zero
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |->
			(res_q.no_inverse ? res_q.inverse == '0 : res_q.inverse < m_q))
		else $error("result out of range");

endmodule

[design/binary_modular_inverse.sv]
// Top level of the binary modular inverse block: stream ports and output register.
// Depends on bmi_pkg and bmi_core.
//
//  channel   | direction | tdata (low bit up)            | tuser
//  s_axis    | in        | value[31:0], modulus[63:32]   | -
//  m_axis    | out       | inverse[30:0], zero pad [31]  | no_inverse
//
// One item at a time. An invalid modulus (zero or negative) finishes in the cycle
// after acceptance. Otherwise the value is first reduced mod the modulus, then
// each Euclid step is one pass of the shared shift-subtract unit over the 32-bit
// dividend plus check and update; up to about 45 steps for 31-bit operands.
// Reset is asynchronous and clears the sequencer and the output valid.
// A result held in the output register does not block the next beat on s_axis;
// the core stalls only when it finishes while that register is still full.
module binary_modular_inverse import bmi_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // value, modulus
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // inverse, zero pad
	output logic                   m_axis_tuser    // no_inverse
);

	logic             res_valid;
	logic             res_ready;
	res_t             res;
	logic             out_valid_q;
	res_t             out_q;

	bmi_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_value   (s_axis_tdata[WIDTH-1:0]),
		.in_modulus (s_axis_tdata[IN_TDATA_W-1:WIDTH]),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// Take a new result when the output register is empty or being drained
	assign res_ready = !out_valid_q || m_axis_tready;

	// Output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	// Output beat payload: hold while stalled
	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'(out_q.inverse);
	assign m_axis_tuser  = out_q.no_inverse;

endmodule

[test/inverse_checker.sv]
// Checker for the binary modular inverse block: watches both stream channels,
// predicts each result with its own extended Euclid model and compares.
// Depends on bmi_pkg.
`timescale 1ns / 1ps

module inverse_checker import bmi_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   m_axis_tuser,
	output int                     fail_count,
	output int                     pending
);

	res_t expected_results[$];
	res_t got;
	res_t want;

	// Inverse of value modulo modulus, or the no-inverse flag
	function automatic res_t modular_inverse(input logic [WIDTH-1:0] value,
			input logic [WIDTH-1:0] modulus);
		longint unsigned m, a, mag, rem;
		longint unsigned r0, r1, t0, t1, q, nr, qt, nt;
		logic [WIDTH-1:0] neg_value;
		res_t r;
		r.inverse    = '0;
		r.no_inverse = 1'b1;
		if (modulus == '0 || modulus[WIDTH-1])
			return r;
		m = modulus;
		// bring a negative value up into 0..m-1
		if (value[WIDTH-1]) begin
			neg_value = -value;
			mag = neg_value;
			rem = mag % m;
			a = (rem != 0) ? m - rem : 0;
		end else begin
			a = value % m;
		end
		// Euclid recurrence with the coefficient kept reduced mod m
		r0 = m;
		r1 = a;
		t0 = 0;
		t1 = 1 % m;
		while (r1 != 0) begin
			q  = r0 / r1;
			nr = r0 - q * r1;
			qt = ((q % m) * t1) % m;
			nt = (t0 >= qt) ? t0 - qt : t0 + (m - qt);
			r0 = r1;
			r1 = nr;
			t0 = t1;
			t1 = nt;
		end
		if (r0 == 1) begin
			r.inverse    = t0[RES_W-1:0];
			r.no_inverse = 1'b0;
		end
		return r;
	endfunction

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	// Compare each result beat with the oldest prediction, then queue new ones
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.inverse    = m_axis_tdata[RES_W-1:0];
				got.no_inverse = m_axis_tuser;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result beat inverse=%0d no_inverse=%0b",
						$time, got.inverse, got.no_inverse);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (got.inverse !== want.inverse) begin
						$display("%0t: inverse mismatch, expected %0d, actual %0d",
							$time, want.inverse, got.inverse);
						fail_count++;
					end
					if (got.no_inverse !== want.no_inverse) begin
						$display("%0t: no_inverse mismatch, expected %0b, actual %0b",
							$time, want.no_inverse, got.no_inverse);
						fail_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(modular_inverse(s_axis_tdata[WIDTH-1:0],
					s_axis_tdata[2*WIDTH-1:WIDTH]));
			pending = expected_results.size();
		end
	end

endmodule

[test/tb_top.sv]
// Testbench top for the binary modular inverse block: clock, reset, operand
// stimulus, result-side back-pressure, watchdog and verdict.
// Depends on bmi_pkg, binary_modular_inverse and inverse_checker.
`timescale 1ns / 1ps

module tb_top import bmi_pkg::*;;

	localparam int RANDOM_ITEMS   = 1530;
	localparam int HOLD_CYCLES    = 4000;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 64;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;

	int fail_count;
	int pending;
	int idle_cycles = 0;
	bit quiet = 1'b0;
	bit hold_req = 1'b0;

	always #4 clk = ~clk;

	binary_modular_inverse u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	inverse_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// Offer one operand beat, with random gaps ahead of it, and hold it until taken
	task automatic send_operands(input logic [WIDTH-1:0] value, input logic [WIDTH-1:0] modulus);
		while (!quiet && $urandom_range(99) < 11) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {modulus, value};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Pick one random operand pair from a mix of operand classes
	task automatic random_operands(output logic [WIDTH-1:0] value,
			output logic [WIDTH-1:0] modulus);
		int unsigned pick;
		logic [WIDTH-1:0] g;
		pick  = $urandom_range(99);
		value = $urandom;
		if (pick < 15) begin
			modulus = $urandom;
		end else if (pick < 45) begin
			modulus = $urandom & 32'h7FFF_FFFF;
		end else if (pick < 65) begin
			modulus = $urandom_range(255, 1);
		end else if (pick < 75) begin
			value   = {{16{value[15]}}, value[15:0]};
			modulus = $urandom & 32'h7FFF_FFFF;
		end else if (pick < 85) begin
			// shared factor: never invertible
			g       = $urandom_range(1000, 2);
			modulus = g * $urandom_range(2000000, 1);
			value   = g * $urandom_range(2000000, 0);
			if ($urandom_range(1))
				value = -value;
		end else if (pick < 95) begin
			modulus = $urandom_range(1) ? 32'h7FFF_FFFF : 32'd65521;
		end else begin
			case ($urandom_range(4))
				0: modulus = 32'd0;
				1: modulus = 32'd1;
				2: modulus = 32'd2;
				3: modulus = 32'h8000_0000;
				default: modulus = 32'hFFFF_FFFF;
			endcase
		end
	endtask

	// Result side: random stalls, plus one long hold-off on request
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= quiet || ($urandom_range(99) >= 11);
			end
		end
	end

	// Watchdog: end the run when no beat moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired, %0d results outstanding", $time, pending);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Stimulus and verdict
	initial begin
		logic [WIDTH-1:0] value;
		logic [WIDTH-1:0] modulus;
		int               drain;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes and special cases
		send_operands(32'd3, 32'd7);
		send_operands(32'd1, 32'd7);
		send_operands(32'd0, 32'd7);
		send_operands(32'd5, 32'd0);
		send_operands(32'h7FFF_FFFF, 32'd0);
		send_operands(32'd5, -32'd7);
		send_operands(32'd0, 32'hFFFF_FFFF);
		send_operands(32'h8000_0000, 32'h8000_0000);
		send_operands(32'hFFFF_FFFF, 32'h7FFF_FFFF);
		send_operands(32'h8000_0000, 32'h7FFF_FFFF);
		send_operands(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_operands(32'h7FFF_FFFF, 32'h7FFF_FFFE);
		send_operands(32'd4, 32'd6);
		send_operands(32'd6, 32'd9);
		send_operands(32'd12345, 32'd1);
		send_operands(32'h8000_0000, 32'd1);
		send_operands(32'd0, 32'd1);
		send_operands(32'h7FFF_FFFF, 32'd2);
		send_operands(32'd1, 32'd2);
		send_operands(-32'd3, 32'd10);
		send_operands(32'd7, 32'h7FFF_FFFE);
		send_operands(32'hAAAA_AAAA, 32'h5555_5555);

		// random: one long result-side hold-off and one quiet stretch
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 100)
				hold_req = 1'b1;
			quiet = (i >= 400 && i < 700);
			random_operands(value, modulus);
			send_operands(value, modulus);
		end
		quiet = 1'b0;
		s_axis_tvalid <= 1'b0;

		// drain outstanding results, then let the block settle
		while (pending != 0)
			@(posedge clk);
		for (drain = 0; drain < DRAIN_CYCLES; drain++)
			@(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
